// ===== rtl/mstt_pkg.sv =====
// Shared codes and the stored slot entry layout of the timer table.
package mstt_pkg;

   // command codes carried on the request tuser
   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_START       = 3'd1;
   localparam logic [2:0] ACT_STOP        = 3'd2;
   localparam logic [2:0] ACT_STOP_REPEAT = 3'd3;
   localparam logic [2:0] ACT_SUSPEND     = 3'd4;
   localparam logic [2:0] ACT_RESUME      = 3'd5;

   // result kinds carried on the response tuser
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_FIRE  = 1'b1;

   localparam int SLOT_IN_W  = 4;
   localparam int SLOT_OUT_W = 4;
   localparam int TIME_W     = 32;

   // one slot as it sits in the entry memory
   typedef struct packed {
      logic              repeating;
      logic              suspended;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== rtl/mstt_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module mstt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/multi_slot_timer_table_core.sv =====
// Timer slot table: command sequencer, slot scan and entry memory.
//
// Usage:
//   req_* takes one command item: tick, start, stop, stop repeat, suspend or
//   resume (req_tuser), with slot, period and repeat mark in req_tdata.
//   rsp_* returns start replies and fire reports; rsp_tlast marks the last
//   item caused by one command. Stop and the other slot commands reply with
//   nothing; a tick on which no slot fires replies with nothing.
//   One command is worked on at a time; req_tready is high only while idle.
//   A tick scans all slots: the scan reads one entry of the entry memory per
//   cycle while not paused, through its single read port, and checks it the
//   cycle after, writing back reloaded deadlines on the same memory's write
//   port. Stop-repeat, suspend and resume read, modify and write back the
//   entry; a start fills the lowest free slot; stop only clears the in-use mark.
//   Each fired slot is held one step so the final one can carry tlast.
//   A stalled receiver holds the output register; the scan pauses when a
//   further item has to leave and the register is still full.
//   Reset clears the tick count, all in-use marks and the output register;
//   the entry memory needs no clearing, since an entry's contents are used
//   only after a start has written it.
module multi_slot_timer_table_core #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[3:0], period[35:4], repeating[36], zero[39:37]
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // slot_number[3:0], success[4], zero[7:5]
   output logic        rsp_tuser,   // result_kind[0]
   output logic        rsp_tlast    // last_of_run
);

   import mstt_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_FLUSH  = 3'd2;
   localparam logic [2:0] ST_START  = 3'd3;
   localparam logic [2:0] ST_CMD_RD = 3'd4;
   localparam logic [2:0] ST_CMD_WR = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [TIME_W-1:0]    count_ff, count_in;
   logic [NUM_SLOTS-1:0] in_use_ff, in_use_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;

   logic [2:0]           act_ff;
   logic [SLOT_IN_W-1:0] slot_ff;
   logic [TIME_W-1:0]    period_ff;
   logic                 rep_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_ok_ff;
   logic                  rsp_last_ff;

   logic                  push;
   logic                  push_kind;
   logic [SLOT_OUT_W-1:0] push_slot;
   logic                  push_ok;
   logic                  push_last;

   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]   rd_word;
   entry_type            rd_entry, wr_entry;

   logic                 accept, out_free, rd_more, fire, stall;
   logic                 slot_ok, free_found;
   logic [IDX_W-1:0]     free_idx, rd_idx, cmd_idx;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_more  = rd_cnt_ff < CNT_W'(NUM_SLOTS);
   assign rd_idx   = rd_cnt_ff[IDX_W-1:0];
   assign cmd_idx  = IDX_W'(slot_ff);
   assign slot_ok  = {3'b000, slot_ff} < 7'(NUM_SLOTS);
   assign rd_entry = entry_type'(rd_word);

   assign fire  = ev_valid_ff && in_use_ff[ev_idx_ff] && !rd_entry.suspended
                  && (rd_entry.deadline <= count_ff);
   assign stall = fire && pend_valid_ff && !out_free;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      in_use_in     = in_use_ff;
      rd_cnt_in     = rd_cnt_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      push          = 1'b0;
      push_kind     = KIND_START;
      push_slot     = '0;
      push_ok       = 1'b0;
      push_last     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = '0;
      ram_raddr     = '0;
      wr_entry      = rd_entry;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  ACT_TICK: begin
                     count_in  = count_ff + TIME_W'(1);
                     rd_cnt_in = '0;
                     state_in  = ST_SCAN;
                  end
                  ACT_START: state_in = ST_START;
                  default:   state_in = ST_CMD_RD;
               endcase
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               if (rd_more) begin
                  ram_re      = 1'b1;
                  ram_raddr   = rd_idx;
                  rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
                  ev_valid_in = 1'b1;
                  ev_idx_in   = rd_idx;
               end else begin
                  ev_valid_in = 1'b0;
               end
               if (fire) begin
                  // release the held report; this one is held in its place
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_kind = KIND_FIRE;
                     push_slot = SLOT_OUT_W'(pend_idx_ff);
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = ev_idx_ff;
                  if (rd_entry.repeating) begin
                     wr_entry.deadline = count_ff + rd_entry.period;
                     ram_we            = 1'b1;
                     ram_waddr         = ev_idx_ff;
                  end else begin
                     in_use_in[ev_idx_ff] = 1'b0;
                  end
               end
            end
            if (!rd_more && !ev_valid_ff) begin
               state_in = ST_FLUSH;
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_kind     = KIND_FIRE;
               push_slot     = SLOT_OUT_W'(pend_idx_ff);
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_START: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = KIND_START;
               push_last = 1'b1;
               if (free_found) begin
                  wr_entry.repeating  = rep_ff;
                  wr_entry.suspended  = 1'b0;
                  wr_entry.period     = period_ff;
                  wr_entry.deadline   = count_ff + period_ff;
                  ram_we              = 1'b1;
                  ram_waddr           = free_idx;
                  in_use_in[free_idx] = 1'b1;
                  push_slot           = SLOT_OUT_W'(free_idx);
                  push_ok             = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         ST_CMD_RD: begin
            state_in = ST_IDLE;
            if (slot_ok && in_use_ff[cmd_idx]) begin
               case (act_ff)
                  ACT_STOP: in_use_in[cmd_idx] = 1'b0;
                  ACT_STOP_REPEAT, ACT_SUSPEND, ACT_RESUME: begin
                     ram_re    = 1'b1;
                     ram_raddr = cmd_idx;
                     state_in  = ST_CMD_WR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_CMD_WR: begin
            ram_we    = 1'b1;
            ram_waddr = cmd_idx;
            case (act_ff)
               ACT_STOP_REPEAT: wr_entry.repeating = 1'b0;
               ACT_SUSPEND:     wr_entry.suspended = 1'b1;
               ACT_RESUME: begin
                  wr_entry.suspended = 1'b0;
                  wr_entry.deadline  = '0;
               end
               default: ram_we = 1'b0;
            endcase
            state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         in_use_ff     <= '0;
         rd_cnt_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         in_use_ff     <= in_use_in;
         rd_cnt_ff     <= rd_cnt_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff   <= ev_idx_in;
      pend_idx_ff <= pend_idx_in;
      if (accept) begin
         act_ff    <= req_tuser;
         slot_ff   <= req_tdata[3:0];
         period_ff <= req_tdata[35:4];
         rep_ff    <= req_tdata[36];
      end
      if (push) begin
         rsp_kind_ff <= push_kind;
         rsp_slot_ff <= push_slot;
         rsp_ok_ff   <= push_ok;
         rsp_last_ff <= push_last;
      end
   end

   mstt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS),
      .ADDR_W(IDX_W)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(wr_entry),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(rd_word)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ok_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_start_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_START) |-> rsp_tlast)
      else $error("start reply without tlast");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!pend_valid_ff && !ev_valid_ff))
      else $error("idle with a fire report or scan entry outstanding");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("entry read and written at once");

   a_scan_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stall) |=> (ev_valid_ff && $stable(ev_idx_ff)))
      else $error("scan entry lost during stall");

endmodule

// ===== test/multi_slot_timer_table_core_tb.sv =====
// Self-checking testbench for the timer slot table: commands in, replies and fire reports out.
`timescale 1ns / 100ps

module multi_slot_timer_table_core_tb;
   import mstt_pkg::*;

   localparam int NUM_SLOTS = 16;
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  slot;
      logic [31:0] period;
      logic        repeating;
   } timer_cmd_type;

   typedef struct packed {
      logic       kind;
      logic [3:0] slot_number;
      logic       success;
      logic       last;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // slot[3:0], period[35:4], repeating[36], zero[39:37]
   logic [2:0]  req_tuser = ACT_TICK;   // action[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // slot_number[3:0], success[4], zero[7:5]
   logic        rsp_tuser;   // result_kind[0]
   logic        rsp_tlast;

   multi_slot_timer_table_core #(.NUM_SLOTS(NUM_SLOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // timer table as the block should hold it
   logic [31:0] tick_now = '0;
   bit          busy    [NUM_SLOTS] = '{default: 1'b0};
   bit          paused  [NUM_SLOTS] = '{default: 1'b0};
   bit          rearm   [NUM_SLOTS] = '{default: 1'b0};
   logic [31:0] deadline [NUM_SLOTS];
   logic [31:0] reload   [NUM_SLOTS];

   timer_cmd_type    cmd_queue [$];
   timer_result_type pending_results [$];

   int  mismatch_count = 0;
   int  ticks_seen = 0;
   int  fires_seen = 0;
   int  max_fires = 0;
   int  grants = 0;
   int  refusals = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   logic req_taken = 1'b0;
   logic idle_off = 1'b1;

   // update the table for one command and queue the results it causes
   task automatic apply_command(input timer_cmd_type cmd);
      timer_result_type batch [$];
      timer_result_type r;
      int i;
      int first_free;
      first_free = -1;
      r = '0;
      case (cmd.action)
         ACT_TICK: begin
            tick_now = tick_now + 32'd1;
            ticks_seen++;
            for (i = 0; i < NUM_SLOTS; i++) begin
               if (busy[i] && !paused[i] && deadline[i] <= tick_now) begin
                  r.kind = KIND_FIRE;
                  r.slot_number = 4'(i);
                  r.success = 1'b0;
                  batch.push_back(r);
                  if (rearm[i]) deadline[i] = tick_now + reload[i];
                  else busy[i] = 1'b0;
               end
            end
            fires_seen += batch.size();
            if (batch.size() > max_fires) max_fires = batch.size();
         end
         ACT_START: begin
            for (i = NUM_SLOTS - 1; i >= 0; i--)
               if (!busy[i]) first_free = i;
            r.kind = KIND_START;
            if (first_free >= 0) begin
               busy[first_free] = 1'b1;
               deadline[first_free] = tick_now + cmd.period;
               reload[first_free] = cmd.period;
               rearm[first_free] = cmd.repeating;
               paused[first_free] = 1'b0;
               r.slot_number = 4'(first_free);
               r.success = 1'b1;
               grants++;
            end else begin
               r.slot_number = 4'd0;
               r.success = 1'b0;
               refusals++;
            end
            batch.push_back(r);
         end
         default: begin
            // slot commands on a free or out-of-range slot do nothing
            if (cmd.slot < NUM_SLOTS && busy[cmd.slot]) begin
               case (cmd.action)
                  ACT_STOP:        busy[cmd.slot] = 1'b0;
                  ACT_STOP_REPEAT: rearm[cmd.slot] = 1'b0;
                  ACT_SUSPEND:     paused[cmd.slot] = 1'b1;
                  ACT_RESUME: begin
                     paused[cmd.slot] = 1'b0;
                     deadline[cmd.slot] = '0;
                  end
                  default: ;
               endcase
            end
         end
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) pending_results.push_back(batch[k]);
   endtask

   task automatic note_mismatch(input string what, input timer_result_type want,
                                input timer_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected kind %0d slot %0d success %0d last %0d,",
                  $time, what, want.kind, want.slot_number, want.success, want.last);
         $display("   got kind %0d slot %0d success %0d last %0d",
                  got.kind, got.slot_number, got.success, got.last);
      end
   endtask

   task automatic queue_cmd(input logic [2:0] action, input logic [3:0] slot,
                            input logic [31:0] period, input logic repeating);
      timer_cmd_type c;
      c.action = action;
      c.slot = slot;
      c.period = period;
      c.repeating = repeating;
      cmd_queue.push_back(c);
   endtask

   // request side: advance to the next item once the current one is taken
   always @(negedge clock) begin
      timer_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_off <= 1'b1;
      end else begin
         idle_off <= (cmd_queue.size() < 40) || ((cmd_queue.size() / 48) % 3 == 1);
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 99) < 15) begin
               send_gap = $urandom_range(0, 14);
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               nxt = cmd_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, nxt.repeating, nxt.period, nxt.slot};
               req_tuser <= nxt.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side: stall in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 99) < 12) begin
         stall_left = $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // predict on each accepted command, check each accepted result
   always @(posedge clock) begin
      timer_cmd_type    seen;
      timer_result_type got;
      timer_result_type want;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.action = req_tuser;
            seen.slot = req_tdata[3:0];
            seen.period = req_tdata[35:4];
            seen.repeating = req_tdata[36];
            apply_command(seen);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.slot_number = rsp_tdata[3:0];
            got.success = rsp_tdata[4];
            got.last = rsp_tlast;
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected result", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.kind != want.kind || got.slot_number != want.slot_number ||
                   got.success != want.success || got.last != want.last)
                  note_mismatch("result mismatch", want, got);
            end
         end
      end
   end

   initial begin
      int          n;
      int          roll;
      int          pick;
      logic [2:0]  act;
      logic [3:0]  sel;
      logic [31:0] per;

      // directed: wrap, suspend/resume, stop repeat, ignored codes, full table, all slots firing
      queue_cmd(ACT_TICK, 4'd0, 32'h0, 1'b0);
      queue_cmd(ACT_START, 4'hF, 32'h0, 1'b0);
      queue_cmd(ACT_START, 4'h0, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(ACT_START, 4'h7, 32'd2, 1'b1);
      queue_cmd(ACT_SPARE_LO, 4'd0, 32'hFFFF_FFFF, 1'b1);
      queue_cmd(ACT_SPARE_HI, 4'hF, 32'h0, 1'b0);
      queue_cmd(ACT_STOP, 4'd9, 32'h0, 1'b0);
      queue_cmd(ACT_SUSPEND, 4'd2, 32'h0, 1'b0);
      queue_cmd(ACT_TICK, 4'd0, 32'h0, 1'b0);
      queue_cmd(ACT_STOP_REPEAT, 4'd1, 32'h0, 1'b0);
      queue_cmd(ACT_RESUME, 4'd2, 32'h0, 1'b0);
      queue_cmd(ACT_TICK, 4'd0, 32'h0, 1'b0);
      for (n = 0; n < NUM_SLOTS - 1; n++)
         queue_cmd(ACT_START, 4'(n), 32'd1, 1'b0);
      queue_cmd(ACT_START, 4'd0, 32'd5, 1'b1);
      queue_cmd(ACT_RESUME, 4'd2, 32'h0, 1'b0);
      queue_cmd(ACT_TICK, 4'd0, 32'h0, 1'b0);
      queue_cmd(ACT_STOP, 4'd2, 32'h0, 1'b0);

      // random: mostly ticks and starts with short periods so slots keep firing
      for (n = 0; n < 330; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) act = ACT_TICK;
         else if (roll < 64) act = ACT_START;
         else if (roll < 74) act = ACT_STOP;
         else if (roll < 81) act = ACT_STOP_REPEAT;
         else if (roll < 88) act = ACT_SUSPEND;
         else if (roll < 96) act = ACT_RESUME;
         else act = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
         sel = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
         per = $urandom;
         if (act == ACT_START) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) per = $urandom_range(0, 20);
            else if (pick == 8) per = 32'hFFFF_FFFF - $urandom_range(0, 20);
         end
         queue_cmd(act, sel, per, 1'($urandom_range(0, 1)));
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * NUM_SLOTS) @(posedge clock);

      $display("Ran %0d ticks: %0d slot fires checked, up to %0d on one tick.",
               ticks_seen, fires_seen, max_fires);
      $display("Starts granted %0d, refused on a full table %0d; %0d results never arrived.",
               grants, refusals, pending_results.size());
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Timed out with %0d results still expected.", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mstt_pkg.sv
rtl/mstt_ram.sv
rtl/multi_slot_timer_table_core.sv
test/multi_slot_timer_table_core_tb.sv
